// ===== sv/v2ypd_pkg.sv =====
// ----------------------------------------------------------------------------
// v2ypd_pkg
// Shared constants and the arctangent table for the yaw/pitch/distance block.
// ----------------------------------------------------------------------------
package v2ypd_pkg;

	localparam int COORD_W   = 24;  // input coordinate width
	localparam int DIFF_W    = 25;  // exact difference width
	localparam int SQ_W      = 48;  // one squared difference
	localparam int HSQ_W     = 49;  // dx^2 + dy^2
	localparam int DSQ_W     = 50;  // dx^2 + dy^2 + dz^2
	localparam int DIST_W    = 25;  // distance root bits
	localparam int HOR_W     = 31;  // horizontal length root bits (14 frac)
	localparam int HOR_SHIFT = 12;  // hsq pre-scale before the root
	localparam int DZ_SHIFT  = 6;   // dz scale to match the horizontal length
	localparam int YAW_W     = 16;
	localparam int PITCH_W   = 15;

	localparam int AT_IN_W   = 32;  // CORDIC operand width at entry
	localparam int CW        = 56;  // CORDIC x/y datapath width
	localparam int ZW        = 32;  // angle accumulator width
	localparam int TAB_FRAC  = 20;  // degrees, fraction bits of the table
	localparam int NORM_TOP  = 52;  // operands normalised up to 2^52
	localparam int NORM_LVLS = 6;   // shifts of 32, 16, 8, 4, 2, 1

	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< TAB_FRAC;
	localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360) <<< TAB_FRAC;

	// atan(2^-i) in degrees, 20 fraction bits
	function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:    a = 32'sd47185920;
			5'd1:    a = 32'sd27855475;
			5'd2:    a = 32'sd14718068;
			5'd3:    a = 32'sd7471121;
			5'd4:    a = 32'sd3750058;
			5'd5:    a = 32'sd1876857;
			5'd6:    a = 32'sd938658;
			5'd7:    a = 32'sd469357;
			5'd8:    a = 32'sd234682;
			5'd9:    a = 32'sd117342;
			5'd10:   a = 32'sd58671;
			5'd11:   a = 32'sd29335;
			5'd12:   a = 32'sd14668;
			5'd13:   a = 32'sd7334;
			5'd14:   a = 32'sd3667;
			5'd15:   a = 32'sd1833;
			5'd16:   a = 32'sd917;
			5'd17:   a = 32'sd458;
			5'd18:   a = 32'sd229;
			5'd19:   a = 32'sd115;
			5'd20:   a = 32'sd57;
			5'd21:   a = 32'sd29;
			5'd22:   a = 32'sd14;
			5'd23:   a = 32'sd7;
			5'd24:   a = 32'sd4;
			5'd25:   a = 32'sd2;
			5'd26:   a = 32'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/v2ypd_if.sv =====
// ----------------------------------------------------------------------------
// v2ypd_pts_if / v2ypd_res_if
// Valid/ready channels for point pairs in and angle/distance results out.
// ----------------------------------------------------------------------------
interface v2ypd_pts_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [v2ypd_pkg::COORD_W-1:0]      src_x;
	logic signed [v2ypd_pkg::COORD_W-1:0]      src_y;
	logic signed [v2ypd_pkg::COORD_W-1:0]      src_z;
	logic signed [v2ypd_pkg::COORD_W-1:0]      dst_x;
	logic signed [v2ypd_pkg::COORD_W-1:0]      dst_y;
	logic signed [v2ypd_pkg::COORD_W-1:0]      dst_z;

	modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
	modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

interface v2ypd_res_if;
	logic                                      valid;
	logic                                      ready;
	logic        [v2ypd_pkg::YAW_W-1:0]        yaw;
	logic signed [v2ypd_pkg::PITCH_W-1:0]      pitch;
	logic        [v2ypd_pkg::DIST_W-1:0]       distance;
	logic                                      same_point;

	modport source (output valid, yaw, pitch, distance, same_point, input ready);
	modport sink   (input valid, yaw, pitch, distance, same_point, output ready);
endinterface

// ===== sv/v2ypd_delay.sv =====
// ----------------------------------------------------------------------------
// v2ypd_delay
// Enabled shift register that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module v2ypd_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < D; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[D-1];

endmodule

// ===== sv/v2ypd_sqrt.sv =====
// ----------------------------------------------------------------------------
// v2ypd_sqrt
// Pipelined restoring square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module v2ypd_sqrt #(
	parameter int N = 25
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*N-1:0] v,
	output logic [N-1:0]   root
);

	logic [2*N-1:0] rad_s  [N+1];
	logic [N+1:0]   rem_s  [N+1];
	logic [N-1:0]   rt_s   [N+1];
	logic [N-1:0]   root_q;

	assign rad_s[0] = v;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;

	for (genvar j = 0; j < N; j++) begin : g_step
		logic [N+1:0] cand;
		logic [N+1:0] trial;
		assign cand  = {rem_s[j][N-1:0], rad_s[j][2*N-1 -: 2]};
		assign trial = {rt_s[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1] <= rad_s[j] << 2;
				if (cand >= trial) begin
					rem_s[j+1] <= cand - trial;
					rt_s[j+1]  <= {rt_s[j][N-2:0], 1'b1};
				end else begin
					rem_s[j+1] <= cand;
					rt_s[j+1]  <= {rt_s[j][N-2:0], 1'b0};
				end
			end
		end
	end

	// remainder is v - r^2; above r means nearer to r + 1
	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= rt_s[N] + N'(rem_s[N] > {2'b00, rt_s[N]});
		end
	end

	assign root = root_q;

endmodule

// ===== sv/v2ypd_atan2.sv =====
// ----------------------------------------------------------------------------
// v2ypd_atan2
// Vectoring CORDIC atan2(num, den) in degrees, 20 fraction bits: half-turn
// pre-rotation, six-level normalising shift, then one iteration per stage.
// ----------------------------------------------------------------------------
module v2ypd_atan2 #(
	parameter int STEPS = 16
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [v2ypd_pkg::AT_IN_W-1:0]    num,
	input  logic signed [v2ypd_pkg::AT_IN_W-1:0]    den,
	output logic signed [v2ypd_pkg::ZW-1:0]         ang
);

	localparam int IW = v2ypd_pkg::AT_IN_W;
	localparam int CW = v2ypd_pkg::CW;
	localparam int ZW = v2ypd_pkg::ZW;
	localparam int NL = v2ypd_pkg::NORM_LVLS;

	logic signed [IW-1:0] xp, yp, ay;
	logic signed [ZW-1:0] zp;
	logic        [IW-1:0] mp;

	logic signed [CW-1:0] nx_s [NL+1];
	logic signed [CW-1:0] ny_s [NL+1];
	logic        [CW-1:0] nm_s [NL+1];
	logic signed [ZW-1:0] nz_s [NL+1];
	logic                 nzero_s [NL+1];

	logic signed [CW-1:0] cx_s [STEPS+1];
	logic signed [CW-1:0] cy_s [STEPS+1];
	logic signed [ZW-1:0] cz_s [STEPS+1];
	logic                 czero_s [STEPS+1];

	// den < 0: turn by half a turn, sign picked by num
	always_comb begin
		if (den[IW-1]) begin
			xp = -den;
			yp = -num;
			zp = num[IW-1] ? -v2ypd_pkg::HALF_TURN : v2ypd_pkg::HALF_TURN;
		end else begin
			xp = den;
			yp = num;
			zp = '0;
		end
		ay = yp[IW-1] ? -yp : yp;
		mp = ($unsigned(xp) > $unsigned(ay)) ? $unsigned(xp) : $unsigned(ay);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s[0]    <= CW'(xp);
			ny_s[0]    <= CW'(yp);
			nm_s[0]    <= CW'(mp);
			nz_s[0]    <= zp;
			nzero_s[0] <= (num == '0) && (den == '0);
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_norm
		localparam int SH = 32 >> k;
		localparam logic [CW-1:0] TH = CW'(1) << (v2ypd_pkg::NORM_TOP - SH);
		always_ff @(posedge clk) begin
			if (en) begin
				if (nm_s[k] < TH) begin
					nx_s[k+1] <= nx_s[k] <<< SH;
					ny_s[k+1] <= ny_s[k] <<< SH;
					nm_s[k+1] <= nm_s[k] << SH;
				end else begin
					nx_s[k+1] <= nx_s[k];
					ny_s[k+1] <= ny_s[k];
					nm_s[k+1] <= nm_s[k];
				end
				nz_s[k+1]    <= nz_s[k];
				nzero_s[k+1] <= nzero_s[k];
			end
		end
	end

	assign cx_s[0]    = nx_s[NL];
	assign cy_s[0]    = ny_s[NL];
	assign cz_s[0]    = nz_s[NL];
	assign czero_s[0] = nzero_s[NL];

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] A = v2ypd_pkg::atan_deg(5'(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + A;
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - A;
				end
				czero_s[i+1] <= czero_s[i];
			end
		end
	end

	// atan2(0, 0) is taken as zero
	assign ang = czero_s[STEPS] ? '0 : cz_s[STEPS];

endmodule

// ===== sv/vector_to_yaw_pitch_distance.sv =====
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_distance
// Yaw, pitch and Euclidean distance from a source to a destination point.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  pts     | in  | src_x/y/z, dst_x/y/z (s24, 8 frac)
//  res     | out | yaw (u16), pitch (s15), distance (u25), same_point
//
//  One transaction per cycle while res is not stalled. The other paths are
//  delayed to match the pitch path: diff, square, sum, the 31-bit horizontal
//  root (32 stages) and the pitch CORDIC (7 + CORDIC_STEPS stages), then a rounding stage.
//  Reset clears only the delay lines, valid bits included. A result held on res freezes the whole
//  pipeline and pts.ready drops with it; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vector_to_yaw_pitch_distance #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	v2ypd_pts_if.sink   pts,
	v2ypd_res_if.source res
);

	localparam int DW     = v2ypd_pkg::DIFF_W;
	localparam int ZW     = v2ypd_pkg::ZW;
	localparam int IW     = v2ypd_pkg::AT_IN_W;
	localparam int LAT_AT = 7 + CORDIC_STEPS;
	localparam int TOTAL  = 36 + LAT_AT;
	localparam int RS     = v2ypd_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] RHALF = ZW'(1) <<< (RS - 1);
	localparam logic signed [ZW-1:0] YAW_FULL = ZW'(360) <<< ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] PLIM = ZW'(90) <<< ANGLE_FRAC_BITS;

	logic en;

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [2*DW-1:0] px, py, pz;
	logic [v2ypd_pkg::SQ_W-1:0] dx2_s2, dy2_s2, dz2_s2;
	logic same_s2;
	logic [v2ypd_pkg::HSQ_W-1:0] hsq_s3;
	logic [v2ypd_pkg::DSQ_W-1:0] dsq_s3;

	logic [v2ypd_pkg::DIST_W-1:0] dist_r, dist_t;
	logic [v2ypd_pkg::HOR_W-1:0]  hor_r;
	logic signed [DW-1:0] dz_h;
	logic signed [ZW-1:0] zy_a, zy_t, zp_t;
	logic same_t, valid_t;

	logic signed [ZW-1:0] yawf, yaww, yawr, pr;
	logic [v2ypd_pkg::YAW_W-1:0]   yaw_q;
	logic [v2ypd_pkg::PITCH_W-1:0] pitch_q;
	logic                          same_q;

	assign en        = !valid_t || res.ready;
	assign pts.ready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(pts.dst_x) - DW'(pts.src_x);
			dy_s1   <= DW'(pts.dst_y) - DW'(pts.src_y);
			dz_s1   <= DW'(pts.dst_z) - DW'(pts.src_z);
			dx2_s2  <= px[v2ypd_pkg::SQ_W-1:0];
			dy2_s2  <= py[v2ypd_pkg::SQ_W-1:0];
			dz2_s2  <= pz[v2ypd_pkg::SQ_W-1:0];
			same_s2 <= (dx_s1 == '0) && (dy_s1 == '0) && (dz_s1 == '0);
			hsq_s3  <= v2ypd_pkg::HSQ_W'(dx2_s2) + v2ypd_pkg::HSQ_W'(dy2_s2);
			dsq_s3  <= v2ypd_pkg::DSQ_W'(dx2_s2) + v2ypd_pkg::DSQ_W'(dy2_s2)
				+ v2ypd_pkg::DSQ_W'(dz2_s2);
		end
	end

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	v2ypd_sqrt #(.N(v2ypd_pkg::DIST_W)) u_sqrt_dist (
		.clk(clk), .en(en), .v(dsq_s3), .root(dist_r)
	);

	v2ypd_sqrt #(.N(v2ypd_pkg::HOR_W)) u_sqrt_hor (
		.clk(clk), .en(en),
		.v({1'b0, hsq_s3, {v2ypd_pkg::HOR_SHIFT{1'b0}}}),
		.root(hor_r)
	);

	v2ypd_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_yaw (
		.clk(clk), .en(en),
		.num(IW'(dx_s1)), .den(IW'(dy_s1)), .ang(zy_a)
	);

	v2ypd_delay #(.W(DW), .D(34)) u_dly_dz (
		.clk(clk), .arst_n(arst_n), .en(en), .d(dz_s1), .q(dz_h)
	);

	v2ypd_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_pitch (
		.clk(clk), .en(en),
		.num({dz_h[DW-1], dz_h, {v2ypd_pkg::DZ_SHIFT{1'b0}}}),
		.den({1'b0, hor_r}), .ang(zp_t)
	);

	v2ypd_delay #(.W(ZW), .D(34)) u_dly_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .d(zy_a), .q(zy_t)
	);

	v2ypd_delay #(.W(v2ypd_pkg::DIST_W), .D(7 + LAT_AT)) u_dly_dist (
		.clk(clk), .arst_n(arst_n), .en(en), .d(dist_r), .q(dist_t)
	);

	// lines up with the CORDIC outputs, one stage ahead of the result register
	v2ypd_delay #(.W(1), .D(TOTAL - 3)) u_dly_same (
		.clk(clk), .arst_n(arst_n), .en(en), .d(same_s2), .q(same_t)
	);

	v2ypd_delay #(.W(1), .D(TOTAL)) u_dly_valid (
		.clk(clk), .arst_n(arst_n), .en(en), .d(pts.valid), .q(valid_t)
	);

	// yaw = 180 - atan2(dx, dy) wrapped into one turn; angles rounded, pitch clamped
	always_comb begin
		yawf = v2ypd_pkg::HALF_TURN - zy_t;
		if (yawf < 0) begin
			yaww = yawf + v2ypd_pkg::FULL_TURN;
		end else if (yawf >= v2ypd_pkg::FULL_TURN) begin
			yaww = yawf - v2ypd_pkg::FULL_TURN;
		end else begin
			yaww = yawf;
		end
		yawr = (yaww + RHALF) >>> RS;
		if (yawr >= YAW_FULL) yawr = '0;
		pr = (zp_t + RHALF) >>> RS;
		if (pr > PLIM) pr = PLIM;
		if (pr < -PLIM) pr = -PLIM;
		if (same_t) pr = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_q   <= yawr[v2ypd_pkg::YAW_W-1:0];
			pitch_q <= pr[v2ypd_pkg::PITCH_W-1:0];
			same_q  <= same_t;
		end
	end

	assign res.valid      = valid_t;
	assign res.yaw        = yaw_q;
	assign res.pitch      = pitch_q;
	assign res.distance   = dist_t;
	assign res.same_point = same_q;

	a_same_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.same_point |-> res.pitch == '0)
		else $error("pitch not zero on coinciding points");

	a_same_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.same_point |-> res.distance == '0)
		else $error("distance not zero on coinciding points");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !pts.ready)
		else $error("input taken while result stalled");

endmodule

// ===== verif/tb_vector_to_yaw_pitch_distance.sv =====
// ----------------------------------------------------------------------------
// tb_vector_to_yaw_pitch_distance
// Streams point pairs through the block and checks yaw, pitch, distance and
// the coincident-point flag of every result against a bit-exact predictor.
// Directed corner cases come first, then random pairs in three idling phases,
// with one long result stall and a drain between phases.
// ----------------------------------------------------------------------------
module tb_vector_to_yaw_pitch_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int TFRAC           = 20;
	localparam int RAND_PER_PHASE  = 600;
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 80;

	typedef struct packed {
		logic signed [v2ypd_pkg::COORD_W-1:0] sx, sy, sz, dx, dy, dz;
	} pair_t;

	typedef struct packed {
		logic        [v2ypd_pkg::YAW_W-1:0]   yaw;
		logic signed [v2ypd_pkg::PITCH_W-1:0] pitch;
		logic        [v2ypd_pkg::DIST_W-1:0]  distance;
		logic                                 same_point;
	} angles_t;

	// atan(2^-i) in degrees, 20 fraction bits
	localparam longint ATAN_DEG [32] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0
	};

	logic clk;
	logic arst_n;
	v2ypd_pts_if pts_ch ();
	v2ypd_res_if res_ch ();

	vector_to_yaw_pitch_distance #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts_ch),
		.res(res_ch)
	);

	pair_t   pending_pairs[$];
	angles_t expected_angles[$];
	int      err_cnt = 0;
	int      src_idle_pct = 0;
	int      dst_idle_pct = 0;
	bit      hold_req = 0;
	bit      pts_fire = 0;
	int      quiet_cycles = 0;

	function automatic longint unsigned root_rounded(longint unsigned v);
		longint unsigned r, b, n;
		r = 0;
		b = 64'd1 << 62;
		n = v;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v - r * r > r)
			r++;
		return r;
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring CORDIC, degrees with 20 fraction bits
	function automatic longint cordic_atan2(longint num, longint den);
		longint x, y, z, xs, ys;
		x = den;
		y = num;
		z = 0;
		if (num == 0 && den == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? (longint'(180) <<< TFRAC) : -(longint'(180) <<< TFRAC);
			x = -x;
			y = -y;
		end
		while (magnitude(x) < (longint'(1) <<< 52) && magnitude(y) < (longint'(1) <<< 52)) begin
			x *= 2;
			y *= 2;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += ATAN_DEG[i % 32];
			end else begin
				x -= ys;
				y += xs;
				z -= ATAN_DEG[i % 32];
			end
		end
		return z;
	endfunction

	function automatic longint round_deg(longint a);
		return (a + (longint'(1) <<< (TFRAC - ANGLE_FRAC_BITS - 1))) >>>
			(TFRAC - ANGLE_FRAC_BITS);
	endfunction

	function automatic angles_t predict_angles(pair_t p);
		angles_t r;
		longint dx, dy, dz, yawf, yw, pt, h, lim, full;
		longint unsigned hsq, dsq;
		dx = longint'(p.dx) - longint'(p.sx);
		dy = longint'(p.dy) - longint'(p.sy);
		dz = longint'(p.dz) - longint'(p.sz);
		hsq = dx * dx + dy * dy;
		dsq = hsq + dz * dz;
		full = longint'(360) <<< TFRAC;
		r.distance   = v2ypd_pkg::DIST_W'(root_rounded(dsq));
		r.same_point = (dx == 0 && dy == 0 && dz == 0);

		yawf = (longint'(180) <<< TFRAC) - cordic_atan2(dx, dy);
		if (yawf < 0)
			yawf += full;
		if (yawf >= full)
			yawf -= full;
		yw = round_deg(yawf);
		if (yw >= (longint'(360) <<< ANGLE_FRAC_BITS))
			yw = 0;
		r.yaw = v2ypd_pkg::YAW_W'(yw);

		if (r.same_point) begin
			pt = 0;
		end else begin
			h = root_rounded(hsq << 12);
			pt = round_deg(cordic_atan2(dz * 64, h));
			lim = longint'(90) <<< ANGLE_FRAC_BITS;
			if (pt > lim)
				pt = lim;
			if (pt < -lim)
				pt = -lim;
		end
		r.pitch = v2ypd_pkg::PITCH_W'(pt);
		return r;
	endfunction

	function automatic logic signed [v2ypd_pkg::COORD_W-1:0] rnd_coord();
		return v2ypd_pkg::COORD_W'($urandom());
	endfunction

	task automatic add_pair(longint sx, longint sy, longint sz,
			longint dx, longint dy, longint dz);
		pair_t p;
		p.sx = v2ypd_pkg::COORD_W'(sx);
		p.sy = v2ypd_pkg::COORD_W'(sy);
		p.sz = v2ypd_pkg::COORD_W'(sz);
		p.dx = v2ypd_pkg::COORD_W'(dx);
		p.dy = v2ypd_pkg::COORD_W'(dy);
		p.dz = v2ypd_pkg::COORD_W'(dz);
		pending_pairs.push_back(p);
	endtask

	task automatic add_random_pairs(int n);
		pair_t p;
		int sel, span;
		for (int k = 0; k < n; k++) begin
			p.sx = rnd_coord(); p.sy = rnd_coord(); p.sz = rnd_coord();
			p.dx = rnd_coord(); p.dy = rnd_coord(); p.dz = rnd_coord();
			sel = $urandom_range(99);
			span = (sel < 60) ? 255 : 65535;
			if (sel >= 40 && sel < 75) begin
				// short vector somewhere in space
				p.dx = v2ypd_pkg::COORD_W'(p.sx + $signed($urandom_range(2 * span)) - span);
				p.dy = v2ypd_pkg::COORD_W'(p.sy + $signed($urandom_range(2 * span)) - span);
				p.dz = v2ypd_pkg::COORD_W'(p.sz + $signed($urandom_range(2 * span)) - span);
			end else if (sel >= 75 && sel < 85) begin
				// each coordinate copied from the source at random: on an axis, in a plane, or neither
				if ($urandom_range(1)) p.dx = p.sx;
				if ($urandom_range(1)) p.dy = p.sy;
				if ($urandom_range(1)) p.dz = p.sz;
			end else if (sel >= 85 && sel < 92) begin
				p.dx = p.sx; p.dy = p.sy; p.dz = p.sz;
			end else if (sel >= 92) begin
				p.dx = v2ypd_pkg::COORD_W'(p.sx + $signed($urandom_range(6)) - 3);
				p.dy = v2ypd_pkg::COORD_W'(p.sy + $signed($urandom_range(6)) - 3);
				p.dz = v2ypd_pkg::COORD_W'(p.sz + $signed($urandom_range(6)) - 3);
			end
			pending_pairs.push_back(p);
		end
	endtask

	task automatic drain();
		while (pending_pairs.size() != 0 || pts_ch.valid || expected_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sender: one transaction offered per cycle at most
	always @(negedge clk) begin : drv
		pair_t p;
		if (arst_n && (pts_fire || !pts_ch.valid)) begin
			if (pending_pairs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				p = pending_pairs.pop_front();
				pts_ch.src_x <= p.sx; pts_ch.src_y <= p.sy; pts_ch.src_z <= p.sz;
				pts_ch.dst_x <= p.dx; pts_ch.dst_y <= p.dy; pts_ch.dst_z <= p.dz;
				pts_ch.valid <= 1'b1;
			end else begin
				pts_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin : rcv
		int hold_cnt;
		bit hold_done;
		if (!arst_n) begin
			hold_cnt = 0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= arst_n && ($urandom_range(99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin : mon
		angles_t got, want;
		bit res_fire;
		pair_t p;
		pts_fire = arst_n && pts_ch.valid && pts_ch.ready;
		res_fire = arst_n && res_ch.valid && res_ch.ready;
		if (pts_fire) begin
			p.sx = pts_ch.src_x; p.sy = pts_ch.src_y; p.sz = pts_ch.src_z;
			p.dx = pts_ch.dst_x; p.dy = pts_ch.dst_y; p.dz = pts_ch.dst_z;
			expected_angles.push_back(predict_angles(p));
		end
		if (res_fire) begin
			got.yaw = res_ch.yaw;
			got.pitch = res_ch.pitch;
			got.distance = res_ch.distance;
			got.same_point = res_ch.same_point;
			if (expected_angles.size() == 0) begin
				$error("result transaction with nothing outstanding");
				err_cnt++;
			end else begin
				want = expected_angles.pop_front();
				if (got.yaw !== want.yaw) begin
					$error("yaw: expected %0d, got %0d", want.yaw, got.yaw);
					err_cnt++;
				end
				if (got.pitch !== want.pitch) begin
					$error("pitch: expected %0d, got %0d", want.pitch, got.pitch);
					err_cnt++;
				end
				if (got.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, got.distance);
					err_cnt++;
				end
				if (got.same_point !== want.same_point) begin
					$error("same_point: expected %0b, got %0b",
						want.same_point, got.same_point);
					err_cnt++;
				end
			end
		end
		if (pts_fire || res_fire || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL vector_to_yaw_pitch_distance");
			$finish;
		end
	end

	initial begin
		longint mx, mn;
		mx = 8388607;
		mn = -8388608;
		arst_n = 0;
		pts_ch.valid = 0;
		pts_ch.src_x = 0; pts_ch.src_y = 0; pts_ch.src_z = 0;
		pts_ch.dst_x = 0; pts_ch.dst_y = 0; pts_ch.dst_z = 0;
		res_ch.ready = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// coincident points, extremes, axis directions, vertical and wrap cases
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(mx, mn, mx, mx, mn, mx);
		add_pair(mn, mn, mn, mx, mx, mx);
		add_pair(mx, mx, mx, mn, mn, mn);
		add_pair(mn, mx, mn, mx, mn, mx);
		add_pair(0, 0, 0, 256, 0, 0);
		add_pair(0, 0, 0, -256, 0, 0);
		add_pair(0, 0, 0, 0, 256, 0);
		add_pair(0, 0, 0, 0, -256, 0);
		add_pair(0, 0, 0, -1, -1, 0);
		add_pair(0, 0, 0, 1, -1, 0);
		add_pair(0, 0, 0, 0, -1000, 0);
		add_pair(0, 0, 0, 1, -8000000, 0);
		add_pair(0, 0, 0, -1, -8000000, 0);
		add_pair(0, 0, 0, 0, 0, 1);
		add_pair(0, 0, 0, 0, 0, -1);
		add_pair(0, 0, mn, 0, 0, mx);
		add_pair(0, 0, mx, 0, 0, mn);
		add_pair(0, 0, 0, 1, 0, 8000000);
		add_pair(0, 0, 0, 1, 1, 1);
		add_pair(5, -7, 3, 5, -7, 3);
		add_pair(mn, 0, 0, mx, 0, 1);
		drain();

		src_idle_pct = 14;
		dst_idle_pct = 54;
		add_random_pairs(RAND_PER_PHASE);
		drain();

		src_idle_pct = 54;
		dst_idle_pct = 14;
		add_random_pairs(RAND_PER_PHASE);
		drain();

		src_idle_pct = 0;
		dst_idle_pct = 0;
		add_random_pairs(RAND_PER_PHASE);
		hold_req = 1;
		drain();

		if (err_cnt == 0)
			$display("PASS vector_to_yaw_pitch_distance");
		else
			$display("FAIL vector_to_yaw_pitch_distance");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/v2ypd_pkg.sv
sv/v2ypd_if.sv
sv/v2ypd_delay.sv
sv/v2ypd_sqrt.sv
sv/v2ypd_atan2.sv
sv/vector_to_yaw_pitch_distance.sv
verif/tb_vector_to_yaw_pitch_distance.sv
